FILE: rtl/avd_pkg.sv
package avd_pkg;

  localparam int unsigned AVD_CORDIC_STAGES = 16;
  localparam int unsigned AVD_SPEED_FRAC_BITS = 3;
  localparam int unsigned AVD_ATAN_LEN = 24;

  localparam int unsigned AVD_MSG_W = 56;
  localparam int unsigned AVD_VEL_W = 13;
  localparam int unsigned AVD_RATE_W = 16;
  localparam int unsigned AVD_SPEED_W = 16;
  localparam int unsigned AVD_ANGLE_W = 16;
  localparam int unsigned AVD_ACC_W = 32;
  localparam int unsigned AVD_FRAC_W = 16;

  localparam logic [2:0] AVD_SUB_SUBSONIC = 3'd1;
  localparam logic [2:0] AVD_SUB_SUPERSONIC = 3'd2;

  localparam logic [15:0] AVD_INV_GAIN = 16'd39797;
  localparam int unsigned AVD_PROD_W = AVD_ACC_W - 1 + 16;

  localparam logic [AVD_ACC_W-1:0] AVD_HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [AVD_ACC_W-1:0] AVD_ATAN [AVD_ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                         ok;
    logic                         nz;
    logic signed [AVD_VEL_W-1:0]  east;
    logic signed [AVD_VEL_W-1:0]  north;
    logic signed [AVD_RATE_W-1:0] climb;
    logic signed [AVD_ACC_W-1:0]  x;
    logic signed [AVD_ACC_W-1:0]  y;
    logic [AVD_ACC_W-1:0]         ang;
  } avd_stage_t;

endpackage

FILE: rtl/avd_decode.sv
module avd_decode import avd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [AVD_MSG_W-1:0] msg_i,
  output logic                 vld_o,
  output avd_stage_t           stg_o
);

  logic [2:0]                   subtype;
  logic                         ok;
  logic                         supersonic;
  logic [9:0]                   ew_raw;
  logic [9:0]                   ns_raw;
  logic [8:0]                   vr_raw;
  logic [9:0]                   ew_mag;
  logic [9:0]                   ns_mag;
  logic [8:0]                   vr_mag;
  logic [AVD_VEL_W-1:0]         ew_scl;
  logic [AVD_VEL_W-1:0]         ns_scl;
  logic [AVD_RATE_W-1:0]        vr_scl;
  logic signed [AVD_VEL_W-1:0]  east;
  logic signed [AVD_VEL_W-1:0]  north;
  logic signed [AVD_RATE_W-1:0] climb;
  logic signed [AVD_VEL_W-1:0]  x_init;
  logic signed [AVD_VEL_W-1:0]  y_init;
  logic                         vld_q;
  avd_stage_t                   stg_d;
  avd_stage_t                   stg_q;

  always_comb begin
    subtype    = msg_i[50:48];
    ok         = (subtype == AVD_SUB_SUBSONIC) || (subtype == AVD_SUB_SUPERSONIC);
    supersonic = (subtype == AVD_SUB_SUPERSONIC);
    ew_raw     = msg_i[41:32];
    ns_raw     = msg_i[30:21];
    vr_raw     = msg_i[18:10];
    ew_mag     = (ew_raw == 10'd0) ? 10'd0 : ew_raw - 10'd1;
    ns_mag     = (ns_raw == 10'd0) ? 10'd0 : ns_raw - 10'd1;
    vr_mag     = (vr_raw == 9'd0) ? 9'd0 : vr_raw - 9'd1;
    ew_scl     = supersonic ? {1'b0, ew_mag, 2'b00} : {3'b000, ew_mag};
    ns_scl     = supersonic ? {1'b0, ns_mag, 2'b00} : {3'b000, ns_mag};
    vr_scl     = {1'b0, vr_mag, 6'b000000};
    east       = msg_i[42] ? -$signed(ew_scl) : $signed(ew_scl);
    north      = msg_i[31] ? -$signed(ns_scl) : $signed(ns_scl);
    climb      = msg_i[19] ? -$signed(vr_scl) : $signed(vr_scl);
    if (!ok) begin
      east  = '0;
      north = '0;
      climb = '0;
    end
    // fold the left half-plane over so the vector starts with x >= 0
    x_init = north[AVD_VEL_W-1] ? -north : north;
    y_init = north[AVD_VEL_W-1] ? -east : east;

    stg_d.ok    = ok;
    stg_d.nz    = (east != '0) || (north != '0);
    stg_d.east  = east;
    stg_d.north = north;
    stg_d.climb = climb;
    stg_d.x     = {{(AVD_ACC_W-AVD_VEL_W-AVD_FRAC_W){x_init[AVD_VEL_W-1]}}, x_init,
                   {AVD_FRAC_W{1'b0}}};
    stg_d.y     = {{(AVD_ACC_W-AVD_VEL_W-AVD_FRAC_W){y_init[AVD_VEL_W-1]}}, y_init,
                   {AVD_FRAC_W{1'b0}}};
    stg_d.ang   = north[AVD_VEL_W-1] ? AVD_HALF_TURN : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

FILE: rtl/avd_cell.sv
module avd_cell import avd_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  avd_stage_t stg_i,
  output logic       vld_o,
  output avd_stage_t stg_o
);

  logic signed [AVD_ACC_W-1:0] dx;
  logic signed [AVD_ACC_W-1:0] dy;
  logic                        vld_q;
  avd_stage_t                  stg_d;
  avd_stage_t                  stg_q;

  always_comb begin
    dx    = stg_i.y >>> IDX;
    dy    = stg_i.x >>> IDX;
    stg_d = stg_i;
    if (!stg_i.y[AVD_ACC_W-1]) begin
      stg_d.x   = stg_i.x + dx;
      stg_d.y   = stg_i.y - dy;
      stg_d.ang = stg_i.ang + AVD_ATAN[IDX];
    end else begin
      stg_d.x   = stg_i.x - dx;
      stg_d.y   = stg_i.y + dy;
      stg_d.ang = stg_i.ang - AVD_ATAN[IDX];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;

endmodule

FILE: rtl/avd_scale.sv
module avd_scale import avd_pkg::*; #(
  parameter int unsigned SPEED_FRAC_BITS = AVD_SPEED_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  avd_stage_t                   stg_i,
  output logic                         done_o,
  output logic                         ok_o,
  output logic signed [AVD_VEL_W-1:0]  east_o,
  output logic signed [AVD_VEL_W-1:0]  north_o,
  output logic [AVD_SPEED_W-1:0]       speed_o,
  output logic [AVD_ANGLE_W-1:0]       angle_o,
  output logic signed [AVD_RATE_W-1:0] climb_o
);

  localparam int unsigned SUM_W = AVD_PROD_W + 1;
  localparam int unsigned SHIFT = AVD_ACC_W - SPEED_FRAC_BITS;
  localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (SHIFT - 1);
  localparam logic [SUM_W-1:0] SAT = SUM_W'({AVD_SPEED_W{1'b1}});

  logic                         vld_q;
  logic                         ok_q;
  logic                         nz_q;
  logic signed [AVD_VEL_W-1:0]  east_q;
  logic signed [AVD_VEL_W-1:0]  north_q;
  logic signed [AVD_RATE_W-1:0] climb_q;
  logic [AVD_ACC_W-1:0]         ang_q;
  logic [AVD_PROD_W-1:0]        prod_d;
  logic [AVD_PROD_W-1:0]        prod_q;
  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             spd;
  logic [AVD_ACC_W-1:0]         ang_rnd;

  logic                         done_q;
  logic                         okr_q;
  logic signed [AVD_VEL_W-1:0]  eastr_q;
  logic signed [AVD_VEL_W-1:0]  northr_q;
  logic signed [AVD_RATE_W-1:0] climbr_q;
  logic [AVD_SPEED_W-1:0]       speed_d;
  logic [AVD_SPEED_W-1:0]       speed_q;
  logic [AVD_ANGLE_W-1:0]       angle_d;
  logic [AVD_ANGLE_W-1:0]       angle_q;

  // x is never negative after the fold
  assign prod_d = AVD_PROD_W'(stg_i.x[AVD_ACC_W-2:0]) * AVD_PROD_W'(AVD_INV_GAIN);

  always_comb begin
    sum     = SUM_W'(prod_q) + ROUND;
    spd     = sum >> SHIFT;
    ang_rnd = ang_q + 32'h0000_8000;
    speed_d = (spd > SAT) ? {AVD_SPEED_W{1'b1}} : spd[AVD_SPEED_W-1:0];
    angle_d = ang_rnd[AVD_ACC_W-1 -: AVD_ANGLE_W];
    if (!nz_q) begin
      speed_d = '0;
      angle_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_i;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= stg_i.ok;
    nz_q     <= stg_i.nz;
    east_q   <= stg_i.east;
    north_q  <= stg_i.north;
    climb_q  <= stg_i.climb;
    ang_q    <= stg_i.ang;
    prod_q   <= prod_d;
    okr_q    <= ok_q;
    eastr_q  <= east_q;
    northr_q <= north_q;
    climbr_q <= climb_q;
    speed_q  <= speed_d;
    angle_q  <= angle_d;
  end

  assign done_o  = done_q;
  assign ok_o    = okr_q;
  assign east_o  = eastr_q;
  assign north_o = northr_q;
  assign speed_o = speed_q;
  assign angle_o = angle_q;
  assign climb_o = climbr_q;

endmodule

FILE: rtl/airborne_velocity_decode.sv
// Decodes one airborne-velocity ME field per request. A request is taken on
// every clock where start_i is high; busy_o never rises, so a new request may
// follow in the very next cycle. Each result appears on the output ports for
// one cycle with done_o high, after it has passed through one decode stage,
// one CORDIC cell per stage and two scaling stages. Results leave in request
// order and cannot be held off, so the receiver must take every cycle in which
// done_o is high. Non-velocity subtypes still produce a result, with every
// field zero.
module airborne_velocity_decode import avd_pkg::*; #(
  parameter int unsigned CORDIC_STAGES   = AVD_CORDIC_STAGES,
  parameter int unsigned SPEED_FRAC_BITS = AVD_SPEED_FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [AVD_MSG_W-1:0]         message_field_i,
  output logic                         done_o,
  output logic                         velocity_valid_o,
  output logic signed [AVD_VEL_W-1:0]  east_velocity_o,
  output logic signed [AVD_VEL_W-1:0]  north_velocity_o,
  output logic [AVD_SPEED_W-1:0]       ground_speed_o,
  output logic [AVD_ANGLE_W-1:0]       track_angle_o,
  output logic signed [AVD_RATE_W-1:0] climb_rate_o
);

  localparam int unsigned NCELLS =
    (CORDIC_STAGES < AVD_ATAN_LEN) ? CORDIC_STAGES : AVD_ATAN_LEN;

  logic       vld [NCELLS+1];
  avd_stage_t stg [NCELLS+1];

  assign busy_o = 1'b0;

  avd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .msg_i  (message_field_i),
    .vld_o  (vld[0]),
    .stg_o  (stg[0])
  );

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    avd_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[i]),
      .stg_i  (stg[i]),
      .vld_o  (vld[i+1]),
      .stg_o  (stg[i+1])
    );
  end

  avd_scale #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vld[NCELLS]),
    .stg_i   (stg[NCELLS]),
    .done_o  (done_o),
    .ok_o    (velocity_valid_o),
    .east_o  (east_velocity_o),
    .north_o (north_velocity_o),
    .speed_o (ground_speed_o),
    .angle_o (track_angle_o),
    .climb_o (climb_rate_o)
  );

endmodule
